### src/crs_pkg.sv
`default_nettype none
package crs_pkg;
	localparam int COORD_W = 32;
	localparam int COEF_W = 38;
	localparam int FRAC_W = 16;
	localparam int T_W = 17;
	localparam int PROD_W = COEF_W + FRAC_W + 1;
	localparam logic [T_W-1:0] T_ONE = 17'h10000;
	localparam int MIN_ANCHORS = 4;
	localparam int CFG_CNT_W = 7;
	localparam int SLOT_W = 6;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic REG_ANCHOR_COUNT = 1'b0;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t up_x;
		coord_t up_y;
		coord_t up_z;
	} anchor_t;
endpackage
`default_nettype wire

### src/crs_if.sv
`default_nettype none
interface crs_in_if;
	import crs_pkg::*;
	logic valid;
	logic ready;
	logic func;
	logic [SLOT_W-1:0] anchor_index;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	coord_t up_x;
	coord_t up_y;
	coord_t up_z;
	logic [T_W-1:0] t;
	modport source(output valid, func, anchor_index, pos_x, pos_y, pos_z, up_x, up_y, up_z, t,
		input ready);
	modport sink(input valid, func, anchor_index, pos_x, pos_y, pos_z, up_x, up_y, up_z, t,
		output ready);
endinterface

interface crs_out_if;
	import crs_pkg::*;
	logic valid;
	logic ready;
	coord_t out_pos_x;
	coord_t out_pos_y;
	coord_t out_pos_z;
	coord_t out_up_x;
	coord_t out_up_y;
	coord_t out_up_z;
	modport source(output valid, out_pos_x, out_pos_y, out_pos_z, out_up_x, out_up_y, out_up_z,
		input ready);
	modport sink(input valid, out_pos_x, out_pos_y, out_pos_z, out_up_x, out_up_y, out_up_z,
		output ready);
endinterface
`default_nettype wire

### src/crs_lane.sv
`default_nettype none
module crs_lane
	import crs_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic [FRAC_W-1:0] u_s2,
	input wire coord_t p0_s2,
	input wire coord_t p1_s2,
	input wire coord_t p2_s2,
	input wire coord_t p3_s2,
	output coord_t res_s10
);
	coef_t pe0, pe1, pe2, pe3;
	coef_t c3_s3, c2_s3, c1_s3, c0_s3;
	coef_t c2_s4, c1_s4, c0_s4, c1_s5, c0_s5, c1_s6, c0_s6, c0_s7, c0_s8;
	logic [FRAC_W-1:0] u_s3, u_s4, u_s5, u_s6, u_s7;
	logic signed [PROD_W-1:0] m1_s4, m2_s6, m3_s8;
	coef_t a2_s5, a3_s7, a4_s9;
	logic signed [PROD_W-1:0] ue3, ue5, ue7;
	logic signed [COEF_W-1:0] half;

	assign pe0 = COEF_W'(p0_s2);
	assign pe1 = COEF_W'(p1_s2);
	assign pe2 = COEF_W'(p2_s2);
	assign pe3 = COEF_W'(p3_s2);
	assign ue3 = PROD_W'($signed({1'b0, u_s3}));
	assign ue5 = PROD_W'($signed({1'b0, u_s5}));
	assign ue7 = PROD_W'($signed({1'b0, u_s7}));
	// Halving rounded half up.
	assign half = (a4_s9 + COEF_W'(1)) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			c3_s3 <= (pe1 <<< 1) + pe1 - (pe2 <<< 1) - pe2 + pe3 - pe0;
			c2_s3 <= (pe0 <<< 1) - (pe1 <<< 2) - pe1 + (pe2 <<< 2) - pe3;
			c1_s3 <= pe2 - pe0;
			c0_s3 <= pe1 <<< 1;
			u_s3 <= u_s2;

			m1_s4 <= PROD_W'(c3_s3) * ue3;
			c2_s4 <= c2_s3;
			c1_s4 <= c1_s3;
			c0_s4 <= c0_s3;
			u_s4 <= u_s3;

			a2_s5 <= c2_s4 + COEF_W'((m1_s4 + PROD_W'(32768)) >>> FRAC_W);
			c1_s5 <= c1_s4;
			c0_s5 <= c0_s4;
			u_s5 <= u_s4;

			m2_s6 <= PROD_W'(a2_s5) * ue5;
			c1_s6 <= c1_s5;
			c0_s6 <= c0_s5;
			u_s6 <= u_s5;

			a3_s7 <= c1_s6 + COEF_W'((m2_s6 + PROD_W'(32768)) >>> FRAC_W);
			c0_s7 <= c0_s6;
			u_s7 <= u_s6;

			m3_s8 <= PROD_W'(a3_s7) * ue7;
			c0_s8 <= c0_s7;

			a4_s9 <= c0_s8 + COEF_W'((m3_s8 + PROD_W'(32768)) >>> FRAC_W);

			if (half > COEF_W'(32'sh7FFFFFFF)) begin
				res_s10 <= 32'sh7FFFFFFF;
			end else if (half < -COEF_W'(64'sh80000000)) begin
				res_s10 <= 32'sh80000000;
			end else begin
				res_s10 <= COORD_W'(half);
			end
		end
	end
endmodule
`default_nettype wire

### src/catmull_rom_anchor_spline.sv
`default_nettype none
// Evaluate items run through a registered pipeline to the output.
// Throughput: one item per cycle unless the output item waits; the anchor table is
// held twice, each copy with two read ports, so all four neighbours are read together.
// Reset is asynchronous, active low: it clears the valid bits and sets anchor_count to 4.
// The anchor table has no reset and holds no meaning until written.
module catmull_rom_anchor_spline
	import crs_pkg::*;
#(
	parameter int MAX_ANCHORS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	crs_in_if.sink in_ch,
	crs_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
	localparam int NW = ($clog2(MAX_ANCHORS + 1) > CFG_CNT_W) ?
		$clog2(MAX_ANCHORS + 1) : CFG_CNT_W;
	localparam int PW = T_W + NW;

	logic [CFG_CNT_W-1:0] anchor_count_q;
	logic en, acc;
	logic [T_W-1:0] tc;
	logic [NW-1:0] cnt, n, dv, slot_w;
	logic [PW-1:0] scaled_s1;
	logic [NW-1:0] n_s1, seg;
	logic [NW:0] seg1, seg2;
	logic [AW-1:0] a0, a1, a2, a3;
	logic [FRAC_W-1:0] u_s2;
	anchor_t mem_a_q [MAX_ANCHORS];
	anchor_t mem_b_q [MAX_ANCHORS];
	anchor_t r0_s2, r1_s2, r2_s2, r3_s2, wr;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ANCHOR_COUNT) ? {25'd0, anchor_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_count_q <= CFG_CNT_W'(MIN_ANCHORS);
		end else if (psel && penable && pwrite && paddr[2] == REG_ANCHOR_COUNT) begin
			anchor_count_q <= pwdata[CFG_CNT_W-1:0];
		end
	end

	// The whole pipeline moves together; it holds only when the output item waits.
	assign en = !v_s10 || out_ch.ready;
	assign in_ch.ready = en;
	assign acc = in_ch.valid && en;

	always_comb begin
		tc = (in_ch.t > T_ONE) ? T_ONE : in_ch.t;
		cnt = NW'(anchor_count_q);
		if (cnt < NW'(MIN_ANCHORS)) begin
			n = NW'(MIN_ANCHORS);
		end else if (cnt > NW'(MAX_ANCHORS)) begin
			n = NW'(MAX_ANCHORS);
		end else begin
			n = cnt;
		end
		dv = n - NW'(1);
		slot_w = NW'(in_ch.anchor_index);
	end

	assign wr = '{pos_x: in_ch.pos_x, pos_y: in_ch.pos_y, pos_z: in_ch.pos_z,
		up_x: in_ch.up_x, up_y: in_ch.up_y, up_z: in_ch.up_z};

	always_ff @(posedge clk) begin
		if (acc && in_ch.func == FUNC_WRITE && slot_w < NW'(MAX_ANCHORS)) begin
			mem_a_q[slot_w[AW-1:0]] <= wr;
			mem_b_q[slot_w[AW-1:0]] <= wr;
		end
	end

	// Segment index and neighbour clamping at both ends.
	always_comb begin
		seg = NW'(scaled_s1 >> FRAC_W);
		seg1 = {1'b0, seg} + (NW + 1)'(1);
		seg2 = {1'b0, seg} + (NW + 1)'(2);
		a1 = seg[AW-1:0];
		a0 = (seg == '0) ? seg[AW-1:0] : AW'(seg - NW'(1));
		if (seg1 >= {1'b0, n_s1}) begin
			a2 = seg[AW-1:0];
			a3 = seg[AW-1:0];
		end else begin
			a2 = seg1[AW-1:0];
			a3 = (seg2 >= {1'b0, n_s1}) ? seg1[AW-1:0] : seg2[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s1 <= PW'(tc) * PW'(dv);
			n_s1 <= n;
			u_s2 <= scaled_s1[FRAC_W-1:0];
			r0_s2 <= mem_a_q[a0];
			r1_s2 <= mem_a_q[a1];
			r2_s2 <= mem_b_q[a2];
			r3_s2 <= mem_b_q[a3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && in_ch.func == FUNC_EVAL;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	assign out_ch.valid = v_s10;

	crs_lane u_pos_x (.clk(clk), .en(en), .u_s2(u_s2), .p0_s2(r0_s2.pos_x),
		.p1_s2(r1_s2.pos_x), .p2_s2(r2_s2.pos_x), .p3_s2(r3_s2.pos_x),
		.res_s10(out_ch.out_pos_x));
	crs_lane u_pos_y (.clk(clk), .en(en), .u_s2(u_s2), .p0_s2(r0_s2.pos_y),
		.p1_s2(r1_s2.pos_y), .p2_s2(r2_s2.pos_y), .p3_s2(r3_s2.pos_y),
		.res_s10(out_ch.out_pos_y));
	crs_lane u_pos_z (.clk(clk), .en(en), .u_s2(u_s2), .p0_s2(r0_s2.pos_z),
		.p1_s2(r1_s2.pos_z), .p2_s2(r2_s2.pos_z), .p3_s2(r3_s2.pos_z),
		.res_s10(out_ch.out_pos_z));
	crs_lane u_up_x (.clk(clk), .en(en), .u_s2(u_s2), .p0_s2(r0_s2.up_x),
		.p1_s2(r1_s2.up_x), .p2_s2(r2_s2.up_x), .p3_s2(r3_s2.up_x),
		.res_s10(out_ch.out_up_x));
	crs_lane u_up_y (.clk(clk), .en(en), .u_s2(u_s2), .p0_s2(r0_s2.up_y),
		.p1_s2(r1_s2.up_y), .p2_s2(r2_s2.up_y), .p3_s2(r3_s2.up_y),
		.res_s10(out_ch.out_up_y));
	crs_lane u_up_z (.clk(clk), .en(en), .u_s2(u_s2), .p0_s2(r0_s2.up_z),
		.p1_s2(r1_s2.up_z), .p2_s2(r2_s2.up_z), .p3_s2(r3_s2.up_z),
		.res_s10(out_ch.out_up_z));
endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
module tb;
	import crs_pkg::*;

	localparam int SLOTS = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_PER_PHASE = 130;

	typedef struct {
		logic func;
		logic [SLOT_W-1:0] slot;
		anchor_t data;
		logic [T_W-1:0] t;
		bit known;
		anchor_t result;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	crs_in_if in_ch();
	crs_out_if out_ch();

	catmull_rom_anchor_spline uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	anchor_t anchor_table [SLOTS];
	bit slot_written [SLOTS];
	logic [CFG_CNT_W-1:0] count_reg = 7'd4;
	anchor_t curve_q[$];
	int mismatches = 0, results_seen = 0, items_sent = 0, cycles = 0;
	int idle_mode = 0;
	bit long_hold = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// One coordinate of the curve: Horner form with round-half-up at each step.
	function automatic coord_t curve_coord(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
		longint u);
		longint c3, c2, c1, c0, a;
		c3 = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
		c2 = 2 * longint'(p0) - 5 * longint'(p1) + 4 * longint'(p2) - longint'(p3);
		c1 = -longint'(p0) + longint'(p2);
		c0 = 2 * longint'(p1);
		a = c3;
		a = c2 + ((a * u + 32768) >>> 16);
		a = c1 + ((a * u + 32768) >>> 16);
		a = c0 + ((a * u + 32768) >>> 16);
		a = (a + 1) >>> 1;
		if (a > 64'sd2147483647) a = 64'sd2147483647;
		if (a < -64'sd2147483648) a = -64'sd2147483648;
		return coord_t'(a);
	endfunction

	function automatic int active_count(logic [CFG_CNT_W-1:0] c);
		if (c < MIN_ANCHORS) return MIN_ANCHORS;
		if (c > SLOTS) return SLOTS;
		return c;
	endfunction

	function automatic anchor_t evaluate_curve(logic [T_W-1:0] t_in);
		int n, seg, i0, i2, i3;
		longint tc, scaled, u;
		anchor_t a0, a1, a2, a3, r;
		n = active_count(count_reg);
		tc = (t_in > T_ONE) ? T_ONE : t_in;
		scaled = tc * (n - 1);
		seg = int'(scaled >> 16);
		u = scaled & 16'hFFFF;
		i0 = (seg == 0) ? 0 : seg - 1;
		if (seg + 1 >= n) begin
			i2 = seg;
			i3 = seg;
		end else begin
			i2 = seg + 1;
			i3 = (seg + 2 >= n) ? i2 : seg + 2;
		end
		a0 = anchor_table[i0]; a1 = anchor_table[seg];
		a2 = anchor_table[i2]; a3 = anchor_table[i3];
		r.pos_x = curve_coord(a0.pos_x, a1.pos_x, a2.pos_x, a3.pos_x, u);
		r.pos_y = curve_coord(a0.pos_y, a1.pos_y, a2.pos_y, a3.pos_y, u);
		r.pos_z = curve_coord(a0.pos_z, a1.pos_z, a2.pos_z, a3.pos_z, u);
		r.up_x = curve_coord(a0.up_x, a1.up_x, a2.up_x, a3.up_x, u);
		r.up_y = curve_coord(a0.up_y, a1.up_y, a2.up_y, a3.up_y, u);
		r.up_z = curve_coord(a0.up_z, a1.up_z, a2.up_z, a3.up_z, u);
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return coord_t'($urandom_range(0, 1) ? 0 : -1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic anchor_t rand_anchor();
		anchor_t a;
		a.pos_x = rand_coord(); a.pos_y = rand_coord(); a.pos_z = rand_coord();
		a.up_x = rand_coord(); a.up_y = rand_coord(); a.up_z = rand_coord();
		return a;
	endfunction

	// Offers one item, holds it until accepted, then updates the predicted state.
	task automatic send_item(row_t r);
		anchor_t exp_res;
		if (idle_mode == 1 || idle_mode == 3) begin
			while ($urandom_range(0, 99) < (idle_mode == 1 ? 82 : 6)) begin
				@(negedge clk);
				in_ch.valid = 1'b0;
			end
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.func = r.func;
		in_ch.anchor_index = r.slot;
		in_ch.pos_x = r.data.pos_x; in_ch.pos_y = r.data.pos_y; in_ch.pos_z = r.data.pos_z;
		in_ch.up_x = r.data.up_x; in_ch.up_y = r.data.up_y; in_ch.up_z = r.data.up_z;
		in_ch.t = r.t;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (r.func == FUNC_WRITE) begin
			anchor_table[r.slot] = r.data;
			slot_written[r.slot] = 1'b1;
		end else begin
			exp_res = evaluate_curve(r.t);
			if (r.known && exp_res != r.result) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row predictor disagrees at t=%0d", r.t);
			end
			curve_q.insert(curve_q.size(), r.known ? r.result : exp_res);
		end
	endtask

	task automatic release_input();
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		release_input();
		while (curve_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_count(logic [31:0] value);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = 3'd0; pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		pwrite = 1'b0; penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		count_reg = value[CFG_CNT_W-1:0];
		if (prdata[CFG_CNT_W-1:0] !== count_reg || pready !== 1'b1) begin
			mismatches++;
			if (mismatches <= 10)
				$display("anchor_count read back %0d, wrote %0d", prdata, count_reg);
		end
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	function automatic row_t write_row(int slot, anchor_t a);
		row_t r;
		r.func = FUNC_WRITE; r.slot = SLOT_W'(slot); r.data = a; r.t = T_W'($urandom);
		r.known = 1'b0; r.result = '0;
		return r;
	endfunction

	function automatic row_t eval_row(logic [T_W-1:0] t_in, bit known, anchor_t res);
		row_t r;
		r.func = FUNC_EVAL; r.slot = SLOT_W'($urandom); r.data = rand_anchor(); r.t = t_in;
		r.known = known; r.result = res;
		return r;
	endfunction

	// Every slot the current count can reach must hold an anchor before any evaluation.
	task automatic fill_reachable();
		for (int s = 0; s < active_count(count_reg); s++)
			if (!slot_written[s]) send_item(write_row(s, rand_anchor()));
	endtask

	task automatic random_phase(int items);
		row_t r;
		for (int k = 0; k < items; k++) begin
			idle_mode = (k / 32) % 4;
			if ($urandom_range(0, 99) < 30) begin
				r = write_row($urandom_range(0, SLOTS - 1), rand_anchor());
			end else begin
				case ($urandom_range(0, 9))
					0: r = eval_row(T_ONE, 1'b0, '0);
					1: r = eval_row(T_W'($urandom_range(65537, 131071)), 1'b0, '0);
					2: r = eval_row(T_W'($urandom_range(0, 3)), 1'b0, '0);
					default: r = eval_row(T_W'($urandom_range(0, 65536)), 1'b0, '0);
				endcase
			end
			send_item(r);
		end
	endtask

	always @(negedge clk) begin
		if (long_hold) begin
			out_ch.ready = 1'b0;
			repeat (300) @(negedge clk);
			long_hold = 1'b0;
		end else if (idle_mode == 2)
			out_ch.ready = ($urandom_range(0, 99) >= 82);
		else if (idle_mode == 3)
			out_ch.ready = ($urandom_range(0, 99) >= 6);
		else
			out_ch.ready = 1'b1;
	end

	always @(posedge clk) begin
		anchor_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.pos_x = out_ch.out_pos_x; got.pos_y = out_ch.out_pos_y;
			got.pos_z = out_ch.out_pos_z; got.up_x = out_ch.out_up_x;
			got.up_y = out_ch.out_up_y; got.up_z = out_ch.out_up_z;
			results_seen++;
			if (curve_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("curve point with none expected: %h", got);
			end else begin
				want = curve_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("curve point %0d: expected %h got %h", results_seen, want, got);
				end
			end
		end
	end

	initial begin
		row_t dir [$];
		anchor_t a_max, a_min, a_mix;
		logic [31:0] counts [6] = '{32'd0, 32'd64, 32'd127, 32'd37, 32'd5, 32'd4};
		in_ch.valid = 1'b0; in_ch.func = FUNC_WRITE; in_ch.anchor_index = '0;
		in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
		in_ch.up_x = '0; in_ch.up_y = '0; in_ch.up_z = '0; in_ch.t = '0;
		out_ch.ready = 1'b1;
		for (int s = 0; s < SLOTS; s++) begin
			slot_written[s] = 1'b0;
			anchor_table[s] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		a_max = {6{32'sh7FFFFFFF}};
		a_min = {6{32'sh80000000}};
		a_mix = {32'sh12345678, -32'sh00010000, 32'sh00008000, 32'sh00000001,
			32'shFFFF0001, 32'sh7FFF0000};
		// Count after reset is four; the ends of the parameter range read off anchors.
		dir.insert(dir.size(), write_row(0, a_max));
		dir.insert(dir.size(), write_row(1, a_min));
		dir.insert(dir.size(), write_row(2, '0));
		dir.insert(dir.size(), write_row(3, a_mix));
		dir.insert(dir.size(), write_row(63, a_mix));
		dir.insert(dir.size(), eval_row(17'd0, 1'b1, a_max));
		dir.insert(dir.size(), eval_row(T_ONE, 1'b1, a_mix));
		dir.insert(dir.size(), eval_row(17'h1FFFF, 1'b1, a_mix));
		dir.insert(dir.size(), eval_row(17'h10001, 1'b1, a_mix));
		dir.insert(dir.size(), eval_row(17'd1, 1'b0, '0));
		dir.insert(dir.size(), eval_row(17'd21845, 1'b0, '0));
		dir.insert(dir.size(), eval_row(17'd32768, 1'b0, '0));
		dir.insert(dir.size(), eval_row(17'd43690, 1'b0, '0));
		dir.insert(dir.size(), eval_row(17'd65535, 1'b0, '0));
		// Alternating extremes push the curve past the 32-bit range.
		dir.insert(dir.size(), write_row(0, a_min));
		dir.insert(dir.size(), write_row(1, a_max));
		dir.insert(dir.size(), write_row(2, a_min));
		dir.insert(dir.size(), write_row(3, a_max));
		dir.insert(dir.size(), eval_row(17'd10923, 1'b0, '0));
		dir.insert(dir.size(), eval_row(17'd32768, 1'b0, '0));
		dir.insert(dir.size(), eval_row(17'd54613, 1'b0, '0));
		foreach (dir[k]) send_item(dir[k]);
		random_phase(RAND_PER_PHASE / 2);
		wait_drained();

		foreach (counts[p]) begin
			write_count(counts[p]);
			idle_mode = 0;
			fill_reachable();
			if (p == 1) long_hold = 1'b1;
			random_phase(RAND_PER_PHASE);
			wait_drained();
		end

		$display("%0d items sent, %0d curve points checked, anchor counts 4 to 127 exercised",
			items_sent, results_seen);
		if (mismatches == 0 && curve_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
